@@ rtl/core/wca_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted covariance accumulator package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package wca_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int MAX_FRAMES_DEF   = 4096;

    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NEW_COEFF = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OLD_COEFF = 2'd2;

    localparam int TOTAL_BITS = 28;
    localparam int OUT_BITS   = 40;
    localparam int SUM_BITS   = 64;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample;
        logic signed [15:0] offset;
        logic [15:0]        weight;
        logic               end_of_set;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [39:0] value;
        logic               last;
    } out_word_t;

    // Divider request/handshake between core and divider
    typedef struct packed {
        logic start;
        logic neg;
    } div_ctl_t;

    function automatic logic [5:0] tri_index(input logic [2:0] i, input logic [2:0] j);
        logic [2:0] hi;
        logic [2:0] lo;
        logic [6:0] t;
        begin
            hi = (i >= j) ? i : j;
            lo = (i >= j) ? j : i;
            t  = 7'(({4'd0, hi} * ({4'd0, hi} + 7'd1)) >> 1);
            return 6'(t + {4'd0, lo});
        end
    endfunction

endpackage

@@ rtl/core/wca_divider.sv @@
// ----------------------------------------------------------------------------
// Weighted covariance divider
// Restoring divider, one quotient bit per cycle: rounded |sum| / total.
// ----------------------------------------------------------------------------
module wca_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  wca_pkg::div_ctl_t                 ctl,
    input  logic [wca_pkg::SUM_BITS-1:0]      mag,
    input  logic [wca_pkg::TOTAL_BITS-1:0]    total,
    output logic                              done,
    output logic signed [wca_pkg::OUT_BITS-1:0] quot
);
    localparam int NB = wca_pkg::SUM_BITS + 1;

    logic [NB-1:0] num_reg, num_next;
    logic [wca_pkg::TOTAL_BITS:0] rem_reg, rem_next;
    logic [wca_pkg::TOTAL_BITS-1:0] den_reg;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic neg_reg;
    logic done_reg, done_next;
    logic [wca_pkg::TOTAL_BITS:0] trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[wca_pkg::TOTAL_BITS-1:0], num_reg[NB-1]};
        if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                num_next = {num_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(NB);
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // numerator is mag + total/2 (65 bits)
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            num_reg <= {1'b0, mag} + {37'd0, total >> 1};
            rem_reg <= '0;
            den_reg <= total;
            neg_reg <= ctl.neg;
        end
        else
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    logic [NB-1:0] q_sat;
    always_comb
    begin
        if (num_reg > NB'(64'h80_0000_0000))
            q_sat = NB'(64'h80_0000_0000);
        else
            q_sat = num_reg;
        if (neg_reg)
            quot = -(wca_pkg::OUT_BITS'(q_sat));
        else if (q_sat == NB'(64'h80_0000_0000))
            quot = {1'b0, {(wca_pkg::OUT_BITS-1){1'b1}}};
        else
            quot = wca_pkg::OUT_BITS'(q_sat);
    end

    assign done = done_reg;
endmodule

@@ rtl/core/wca_core.sv @@
// ----------------------------------------------------------------------------
// Weighted covariance core
// Sequencer with pair-sum and matrix memories; MAC per pair, blend per entry.
// ----------------------------------------------------------------------------
module wca_core
#(
    parameter int MAX_CHANNELS = wca_pkg::MAX_CHANNELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  wca_pkg::in_word_t   item,
    input  logic [3:0]          channels_in_use,
    input  logic signed [15:0]  new_coeff,
    input  logic signed [15:0]  old_coeff,
    output logic                busy,
    output logic                strobe,
    output wca_pkg::out_word_t  result
);
    localparam int PAIRS = MAX_CHANNELS * (MAX_CHANNELS + 1) / 2;
    localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MRD   = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_BRD   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_BM1   = 4'd7;
    localparam logic [3:0] S_BM2   = 4'd8;
    localparam logic [3:0] S_BWR   = 4'd9;
    localparam logic [3:0] S_ERD   = 4'd10;
    localparam logic [3:0] S_EOUT  = 4'd11;
    localparam logic [3:0] S_CLR   = 4'd12;
    localparam logic [3:0] S_DST   = 4'd13;

    // memories
    logic signed [63:0] sum_mem [PAIRS];
    logic signed [39:0] mat_mem [PAIRS];
    logic [PAIRS-1:0] sum_vld_reg, mat_vld_reg;
    logic signed [63:0] sum_rd_reg;
    logic signed [39:0] mat_rd_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr_reg;

    logic signed [16:0] fv_reg [MAX_CHANNELS];

    logic [3:0]  state_reg;
    logic [2:0]  pos_reg, j_reg, r_reg, c_reg, n_m1_reg;
    logic [15:0] fw_reg;
    logic [27:0] total_reg;
    logic        eos_reg;
    logic signed [16:0] diff_reg;
    logic signed [33:0] vv_reg;
    logic signed [63:0] prod_reg;
    logic signed [39:0] q_reg;
    logic signed [56:0] b1_reg, b2_reg;
    logic        strobe_reg;
    wca_pkg::out_word_t out_reg;

    logic [2:0] n_m1;
    always_comb
    begin
        if (channels_in_use == 4'd0)
            n_m1 = 3'd0;
        else if (channels_in_use > 4'(MAX_CHANNELS))
            n_m1 = 3'(MAX_CHANNELS - 1);
        else
            n_m1 = 3'(channels_in_use - 4'd1);
    end

    logic [AW-1:0] k_mac, k_blend, k_emit;
    assign k_mac   = AW'(wca_pkg::tri_index(pos_reg, j_reg));
    assign k_blend = AW'(wca_pkg::tri_index(r_reg, c_reg));
    assign k_emit  = k_blend;

    // divider, started once the pair sum read has landed
    wca_pkg::div_ctl_t div_ctl;
    logic div_done;
    logic signed [39:0] div_q;
    logic [63:0] sum_mag;
    logic signed [63:0] sum_cur;
    assign sum_cur = sum_vld_reg[rd_addr_reg] ? sum_rd_reg : 64'sd0;
    assign sum_mag = sum_cur[63] ? 64'(-sum_cur) : 64'(sum_cur);
    assign div_ctl.start = (state_reg == S_DST) && (total_reg != 28'd0);
    assign div_ctl.neg   = sum_cur[63];

    wca_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .mag   (sum_mag),
        .total (total_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // product magnitude pieces
    logic [33:0] vv_mag;
    logic [49:0] wp_mag;
    assign vv_mag = vv_reg[33] ? 34'(-vv_reg) : 34'(vv_reg);
    assign wp_mag = 50'(vv_mag) * 50'(fw_reg);

    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_sat;
    logic signed [63:0] sum_old;
    assign sum_old = sum_vld_reg[rd_addr_reg] ? sum_rd_reg : 64'sd0;
    assign acc_sum = 65'(sum_old) + 65'(prod_reg);
    always_comb
    begin
        if (acc_sum[64] != acc_sum[63])
            acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            acc_sat = acc_sum[63:0];
    end

    logic signed [39:0] mat_old;
    assign mat_old = mat_vld_reg[rd_addr_reg] ? mat_rd_reg : 40'sd0;

    logic signed [57:0] bsum;
    logic signed [43:0] bsh;
    logic signed [39:0] bsat;
    assign bsum = 58'(b1_reg) + 58'(b2_reg) + 58'sd8192;
    assign bsh  = 44'(bsum >>> 14);
    always_comb
    begin
        if (bsh > 44'sh07F_FFFF_FFFF)
            bsat = {1'b0, {39{1'b1}}};
        else if (bsh < -44'sh080_0000_0000)
            bsat = {1'b1, 39'd0};
        else
            bsat = 40'(bsh);
    end

    logic [2:0] pos_eff;
    assign pos_eff = (pos_reg > n_m1) ? n_m1 : pos_reg;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = k_mac;
        unique case (state_reg)
            S_MRD:  begin rd_en = 1'b1; rd_addr = k_mac;   end
            S_BRD:  begin rd_en = 1'b1; rd_addr = k_blend; end
            S_ERD:  begin rd_en = 1'b1; rd_addr = k_emit;  end
            default: begin rd_en = 1'b0; rd_addr = k_mac;  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sum_rd_reg  <= sum_mem[rd_addr];
            mat_rd_reg  <= mat_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (state_reg == S_ACC)
            sum_mem[rd_addr_reg] <= acc_sat;
        if (state_reg == S_BWR)
            mat_mem[rd_addr_reg] <= bsat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            fw_reg      <= '0;
            total_reg   <= '0;
            sum_vld_reg <= '0;
            mat_vld_reg <= '0;
            strobe_reg  <= 1'b0;
            j_reg       <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            eos_reg     <= 1'b0;
            n_m1_reg    <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        logic [15:0] fw_use;
                        logic [28:0] tsum;
                        fw_use = (pos_eff == 3'd0) ? item.weight : fw_reg;
                        if (pos_eff == 3'd0)
                        begin
                            fw_reg <= item.weight;
                            tsum = {1'b0, total_reg} + 29'(item.weight);
                            total_reg <= tsum[28] ? {28{1'b1}} : tsum[27:0];
                        end
                        pos_reg  <= pos_eff;
                        n_m1_reg <= n_m1;
                        eos_reg  <= item.end_of_set;
                        j_reg    <= '0;
                        diff_reg <= 17'(item.sample) - 17'(item.offset);
                        if (fw_use != 16'd0)
                            state_reg <= S_MRD;
                        else if (item.end_of_set)
                        begin
                            r_reg <= '0; c_reg <= '0;
                            state_reg <= S_BRD;
                        end
                        else
                            state_reg <= S_CLR;
                    end
                end
                S_MRD:  state_reg <= S_MUL1;
                S_MUL1: state_reg <= S_MUL2;
                S_MUL2: state_reg <= S_ACC;
                S_ACC:
                begin
                    sum_vld_reg[rd_addr_reg] <= 1'b1;
                    if (j_reg == pos_reg)
                    begin
                        if (eos_reg)
                        begin
                            r_reg <= '0; c_reg <= '0;
                            state_reg <= S_BRD;
                        end
                        else
                            state_reg <= S_CLR;
                    end
                    else
                    begin
                        j_reg <= j_reg + 3'd1;
                        state_reg <= S_MRD;
                    end
                end
                S_BRD:
                begin
                    state_reg <= S_DST;
                end
                S_DST:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (total_reg == 28'd0 || div_done)
                        state_reg <= S_BM1;
                end
                S_BM1:  state_reg <= S_BM2;
                S_BM2:  state_reg <= S_BWR;
                S_BWR:
                begin
                    mat_vld_reg[rd_addr_reg] <= 1'b1;
                    if (c_reg == r_reg)
                    begin
                        c_reg <= '0;
                        if (r_reg == n_m1_reg)
                        begin
                            r_reg <= '0;
                            state_reg <= S_ERD;
                        end
                        else
                        begin
                            r_reg <= r_reg + 3'd1;
                            state_reg <= S_BRD;
                        end
                    end
                    else
                    begin
                        c_reg <= c_reg + 3'd1;
                        state_reg <= S_BRD;
                    end
                end
                S_ERD:  state_reg <= S_EOUT;
                S_EOUT:
                begin
                    strobe_reg <= 1'b1;
                    if (c_reg == n_m1_reg)
                    begin
                        c_reg <= '0;
                        if (r_reg == n_m1_reg)
                        begin
                            sum_vld_reg <= '0;
                            total_reg   <= '0;
                            fw_reg      <= '0;
                            pos_reg     <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            r_reg <= r_reg + 3'd1;
                            state_reg <= S_ERD;
                        end
                    end
                    else
                    begin
                        c_reg <= c_reg + 3'd1;
                        state_reg <= S_ERD;
                    end
                end
                S_CLR:
                begin
                    pos_reg   <= (pos_reg == n_m1_reg) ? 3'd0 : pos_reg + 3'd1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            fv_reg[pos_eff] <= 17'(item.sample) - 17'(item.offset);
        if (state_reg == S_MRD)
            vv_reg <= 34'(diff_reg) * 34'(fv_reg[j_reg]);
        if (state_reg == S_MUL1)
            prod_reg <= vv_reg[33] ? -(64'(wp_mag)) : 64'(wp_mag);
        if (state_reg == S_DIV)
            q_reg <= (total_reg == 28'd0) ? 40'sd0 : div_q;
        if (state_reg == S_BM1)
            b1_reg <= 57'(old_coeff) * 57'(mat_old);
        if (state_reg == S_BM2)
            b2_reg <= 57'(new_coeff) * 57'(q_reg);
        if (state_reg == S_EOUT)
        begin
            out_reg.row   <= r_reg;
            out_reg.col   <= c_reg;
            out_reg.value <= mat_old;
            out_reg.last  <= (r_reg == n_m1_reg) && (c_reg == n_m1_reg);
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = out_reg;
endmodule

@@ rtl/core/weighted_covariance_accumulator.sv @@
// ----------------------------------------------------------------------------
// Weighted covariance accumulator
// Accumulates weighted pair products per frame; blends and emits the matrix.
// Each sample updates the pairs of its channel with channels 0..pos, one
// read-modify-write of a pair memory word per pair (read, multiply, weight,
// accumulate). End of set blends each lower-triangle entry (read, 65-step
// divider that is skipped when the total weight is zero, blend, write), then
// emits every matrix entry as a word. Results are strobed; the receiver cannot
// stall. Reset (async, active low) clears all sums, weight and matrix.
// ----------------------------------------------------------------------------
module weighted_covariance_accumulator
#(
    parameter int MAX_CHANNELS = wca_pkg::MAX_CHANNELS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  wca_pkg::in_word_t                   in_word,
    output logic                                strobe,
    output wca_pkg::out_word_t                  out_word,
    input  logic                                cfg_we,
    input  logic [wca_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [wca_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    logic [3:0]         channels_reg;
    logic signed [15:0] new_coeff_reg, old_coeff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg  <= 4'd8;
            new_coeff_reg <= 16'sd16384;
            old_coeff_reg <= 16'sd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == wca_pkg::REG_CHANNELS)
                channels_reg <= cfg_data[3:0];
            else if (cfg_index == wca_pkg::REG_NEW_COEFF)
                new_coeff_reg <= cfg_data;
            else if (cfg_index == wca_pkg::REG_OLD_COEFF)
                old_coeff_reg <= cfg_data;
        end
    end

    wca_core
    #(
        .MAX_CHANNELS (MAX_CHANNELS)
    )
    u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .item            (in_word),
        .channels_in_use (channels_reg),
        .new_coeff       (new_coeff_reg),
        .old_coeff       (old_coeff_reg),
        .busy            (busy),
        .strobe          (strobe),
        .result          (out_word)
    );
endmodule

@@ rtl/core/wca_checker.sv @@
// ----------------------------------------------------------------------------
// Weighted covariance checker
// Port-level properties of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module wca_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               strobe,
    input wca_pkg::out_word_t out_word
);
    // accepted item makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy after accept");

    // final word sits on the diagonal
    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && out_word.last) |-> (out_word.row == out_word.col))
        else $error("last not on diagonal");

    // strobes come with busy still high except the final word
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !out_word.last) |-> busy) else $error("idle mid-matrix");

    // final word goes out once the block is idle again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && out_word.last) |-> !busy) else $error("busy on last word");

    // words are never strobed back to back
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe) else $error("strobes back to back");
endmodule

bind weighted_covariance_accumulator wca_checker u_wca_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .strobe   (strobe),
    .out_word (out_word)
);
